### hw/rtl/esm_pkg.sv
// ----------------------------------------------------------------------------
// esm_pkg - shared definitions for the encoder speed and stall monitor
// Field widths, register indexes, reset values and the sequencer states.
// ----------------------------------------------------------------------------
package esm_pkg;

   // field widths
   localparam int CountWidth  = 16;
   localparam int TimeWidth   = 32;
   localparam int SpeedWidth  = 16;
   localparam int CsrWidth    = 16;
   localparam int CsrIdxWidth = 2;
   localparam int ReqDataWidth = 72;   // 65 bits of fields, padded to bytes
   localparam int RspDataWidth = 40;   // 34 bits of fields, padded to bytes

   // divider geometry: 31-bit numerator magnitude over a 48-bit denominator
   localparam int NumWidth  = 31;
   localparam int DenWidth  = CsrWidth + TimeWidth;
   localparam int IterWidth = 5;
   localparam int DivSteps  = NumWidth;

   // rpm scale: 60 s times 1000 ms
   localparam logic [15:0] SCALE_NUM = 16'd60000;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] REG_COUNTS_PER_REV  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] REG_WINDOW_MS       = 2'd1;
   localparam logic [CsrIdxWidth-1:0] REG_STALL_MIN_COUNT = 2'd2;

   // configuration reset values
   localparam logic [CsrWidth-1:0] RST_COUNTS_PER_REV  = 16'd44;
   localparam logic [CsrWidth-1:0] RST_WINDOW_MS       = 16'd500;
   localparam logic [CsrWidth-1:0] RST_STALL_MIN_COUNT = 16'd3;

   // saturation limits
   localparam logic [SpeedWidth-1:0] SPEED_MAX = 16'h7FFF;
   localparam logic [SpeedWidth-1:0] SPEED_MIN = 16'h8000;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } esm_state_type;

endpackage

### hw/rtl/encoder_speed_and_stall_monitor.sv
// ----------------------------------------------------------------------------
// encoder_speed_and_stall_monitor - encoder speed and stall monitor
// Measures shaft speed from encoder snapshots and flags stalls per window.
// ----------------------------------------------------------------------------
// A control tick runs through these steps before the block can take the next
// tick: take the tick and update the window state, then two multipliers form
// the numerator |delta|*60000 and the denominator counts_per_rev*dt, then a
// restoring divider settles one quotient bit per cycle with a 49-bit compare
// and subtract, and last the result is saturated and loaded into the result
// register. That last step repeats for as long as the previous result still
// waits on the rsp side; a tick may be taken while such a result waits.
// Configuration writes are taken in any cycle out of reset (csr_ready is high
// whenever reset is low) and must only be issued while no tick is in flight.
// The monitor state resets to zero, so the first tick after reset measures
// against count 0, time 0.
module encoder_speed_and_stall_monitor (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: encoder_count[15:0], now_ms[47:16], target_speed[63:48],
   //        link_ok[64], zero pad[71:65]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [esm_pkg::ReqDataWidth-1:0] req_tdata,
   // tdata: speed_rpm[15:0], effective_target[31:16], stall_fault[32],
   //        drive_online[33], zero pad[39:34]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [esm_pkg::RspDataWidth-1:0] rsp_tdata,
   // configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [esm_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [esm_pkg::CsrWidth-1:0]     csr_data
);

   esm_pkg::esm_state_type state_ff, state_in;

   // configuration registers
   logic [esm_pkg::CsrWidth-1:0]   cpr_ff, window_ms_ff, stall_min_ff;

   // monitor state
   logic [esm_pkg::CountWidth-1:0] prev_count_ff;
   logic [esm_pkg::TimeWidth-1:0]  prev_time_ff, window_start_ff;
   logic [esm_pkg::CountWidth-1:0] window_sum_ff;
   logic                           fault_ff, online_ff;

   // per-tick working registers
   logic [esm_pkg::CountWidth-1:0] mag_ff;
   logic                           neg_ff;
   logic [esm_pkg::TimeWidth-1:0]  dt_ff;
   logic [esm_pkg::SpeedWidth-1:0] target_ff;
   logic [esm_pkg::NumWidth-1:0]   num_ff, num_in;
   logic [esm_pkg::DenWidth-1:0]   den_ff;
   logic [esm_pkg::DenWidth-1:0]   rem_ff, rem_in;
   logic [esm_pkg::NumWidth-1:0]   quot_ff, quot_in;
   logic [esm_pkg::IterWidth-1:0]  iter_ff;

   // result register
   logic                             rsp_valid_ff;
   logic [esm_pkg::RspDataWidth-1:0] rsp_data_ff;

   // handshake decode
   logic req_fire, csr_fire, rsp_load, iter_last;

   // input fields
   logic [esm_pkg::CountWidth-1:0] in_count;
   logic [esm_pkg::TimeWidth-1:0]  in_now;
   logic [esm_pkg::SpeedWidth-1:0] in_cmd;
   logic                           in_link;

   // tick front end
   logic [esm_pkg::CountWidth-1:0] delta;
   logic                           delta_neg;
   logic [esm_pkg::CountWidth-1:0] delta_mag;
   logic [esm_pkg::TimeWidth-1:0]  dt_raw, dt_eff, elapsed;
   logic                           win_end, moving, tgt_nz;
   logic [esm_pkg::CountWidth-1:0] sum_new;
   logic [esm_pkg::SpeedWidth-1:0] target;

   // multiply and divide datapath
   logic [esm_pkg::CsrWidth-1:0]   cpr_eff;
   logic [31:0]                    num_prod;
   logic [esm_pkg::DenWidth-1:0]   den_prod;
   logic [esm_pkg::DenWidth:0]     rem_sh;
   logic                           rem_ge;

   // saturation
   logic [esm_pkg::SpeedWidth-1:0] speed;
   logic                           pos_over, neg_over;

   assign req_fire  = req_tvalid && req_tready;
   assign csr_ready = !reset;
   assign csr_fire  = csr_valid && csr_ready;
   assign iter_last = (iter_ff == esm_pkg::IterWidth'(esm_pkg::DivSteps - 1));

   assign in_count = req_tdata[15:0];
   assign in_now   = req_tdata[47:16];
   assign in_cmd   = req_tdata[63:48];
   assign in_link  = req_tdata[64];

   // count delta as signed 16 bits, its magnitude and the clamped elapsed time
   assign delta     = in_count - prev_count_ff;
   assign delta_neg = delta[15];
   assign delta_mag = delta_neg ? (~delta + 16'd1) : delta;
   assign dt_raw    = in_now - prev_time_ff;
   assign dt_eff    = (dt_raw == '0) ? 32'd1 : dt_raw;

   // stall window bookkeeping
   assign elapsed = in_now - window_start_ff;
   assign win_end = (elapsed >= {16'd0, window_ms_ff});
   assign sum_new = window_sum_ff + delta_mag;
   assign moving  = (sum_new >= stall_min_ff);
   assign target  = in_link ? in_cmd : '0;
   assign tgt_nz  = (target != '0);

   // numerator and denominator products
   assign cpr_eff  = (cpr_ff == '0) ? 16'd1 : cpr_ff;
   assign num_prod = {16'd0, mag_ff} * {16'd0, esm_pkg::SCALE_NUM};
   assign den_prod = {32'd0, cpr_eff} * {16'd0, dt_ff};

   // one restoring divide step
   assign rem_sh = {rem_ff, num_ff[esm_pkg::NumWidth-1]};
   assign rem_ge = (rem_sh >= {1'b0, den_ff});
   assign rem_in = rem_ge ? esm_pkg::DenWidth'(rem_sh - {1'b0, den_ff})
                          : rem_sh[esm_pkg::DenWidth-1:0];
   assign quot_in = {quot_ff[esm_pkg::NumWidth-2:0], rem_ge};
   assign num_in  = {num_ff[esm_pkg::NumWidth-2:0], 1'b0};

   // saturate the signed quotient to 16 bits
   assign pos_over = |quot_ff[30:15];
   assign neg_over = (|quot_ff[30:16]) || (quot_ff[15] && (|quot_ff[14:0]));
   always_comb begin
      if (neg_ff) begin
         speed = neg_over ? esm_pkg::SPEED_MIN : (~quot_ff[15:0] + 16'd1);
      end else begin
         speed = pos_over ? esm_pkg::SPEED_MAX : quot_ff[15:0];
      end
   end

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= esm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer next state and controls
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         esm_pkg::ST_IDLE: begin
            req_tready = !reset;
            if (req_fire) begin
               state_in = esm_pkg::ST_MUL;
            end
         end
         esm_pkg::ST_MUL: begin
            state_in = esm_pkg::ST_DIV;
         end
         esm_pkg::ST_DIV: begin
            if (iter_last) begin
               state_in = esm_pkg::ST_OUT;
            end
         end
         esm_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = esm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = esm_pkg::ST_IDLE;
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff       <= esm_pkg::RST_COUNTS_PER_REV;
         window_ms_ff <= esm_pkg::RST_WINDOW_MS;
         stall_min_ff <= esm_pkg::RST_STALL_MIN_COUNT;
      end else if (csr_fire) begin
         unique case (csr_index)
            esm_pkg::REG_COUNTS_PER_REV:  cpr_ff       <= csr_data;
            esm_pkg::REG_WINDOW_MS:       window_ms_ff <= csr_data;
            esm_pkg::REG_STALL_MIN_COUNT: stall_min_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // monitor state, updated on each tick transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff   <= '0;
         prev_time_ff    <= '0;
         window_start_ff <= '0;
         window_sum_ff   <= '0;
         fault_ff        <= 1'b0;
         online_ff       <= 1'b0;
      end else if (req_fire) begin
         prev_count_ff <= in_count;
         prev_time_ff  <= in_now;
         if (win_end) begin
            window_start_ff <= in_now;
            window_sum_ff   <= '0;
            online_ff       <= tgt_nz && moving;
            if (tgt_nz) begin
               fault_ff <= !moving;
            end
         end else begin
            window_sum_ff <= sum_new;
         end
      end
   end

   // working registers of the current tick
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mag_ff    <= delta_mag;
         neg_ff    <= delta_neg;
         dt_ff     <= dt_eff;
         target_ff <= target;
      end
   end

   // divider registers
   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
      end else if (state_ff == esm_pkg::ST_MUL) begin
         iter_ff <= '0;
      end else if (state_ff == esm_pkg::ST_DIV) begin
         iter_ff <= iter_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == esm_pkg::ST_MUL) begin
         num_ff  <= num_prod[esm_pkg::NumWidth-1:0];
         den_ff  <= den_prod;
         rem_ff  <= '0;
         quot_ff <= '0;
      end else if (state_ff == esm_pkg::ST_DIV) begin
         num_ff  <= num_in;
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {6'd0, online_ff, fault_ff, target_ff, speed};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### hw/rtl/esm_checker.sv
// ----------------------------------------------------------------------------
// esm_checker - port-level checks for the encoder speed and stall monitor
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module esm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [esm_pkg::RspDataWidth-1:0] rsp_tdata
);

   // no result is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // a stalled result stays offered and unchanged
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // a tick never produces its result in the cycle after its transfer
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared too early after a tick transfer");

   // stall fault and online are never reported together
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[32] && rsp_tdata[33]))
      else $error("stall fault and online both set");

   // padding bits of the result are zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39:34] == 6'd0))
      else $error("result padding not zero");

endmodule

bind encoder_speed_and_stall_monitor esm_checker u_esm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### verif/encoder_speed_and_stall_monitor_tb.sv
// ----------------------------------------------------------------------------
// encoder_speed_and_stall_monitor_tb - self-checking bench for the monitor
// Drives control ticks over the req stream and predicts speed, effective
// target and the stall/online flags for every tick. Each rsp transfer is
// compared with the oldest prediction. Directed edge cases come first, then
// random tick sequences under several register settings, with random gaps on
// both streams and one long receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module encoder_speed_and_stall_monitor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint RpmScale   = 60000;
   localparam int     CycleLimit = 600000;
   localparam int     DrainCycles = 40;

   // one control tick as carried on req_tdata
   typedef struct packed {
      logic               link;
      logic signed [15:0] target;
      logic [31:0]        now;
      logic [15:0]        count;
   } tick_type;

   // one reading as carried on rsp_tdata
   typedef struct {
      logic signed [15:0] speed;
      logic signed [15:0] eff_target;
      logic               fault;
      logic               online;
   } reading_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [esm_pkg::ReqDataWidth-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [esm_pkg::RspDataWidth-1:0] rsp_tdata;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [esm_pkg::CsrIdxWidth-1:0]  csr_index = '0;
   logic [esm_pkg::CsrWidth-1:0]     csr_data = '0;

   // predicted readings, oldest first
   reading_type expected_readings[$];

   // register copies
   logic [15:0] cfg_cpr    = esm_pkg::RST_COUNTS_PER_REV;
   logic [15:0] cfg_window = esm_pkg::RST_WINDOW_MS;
   logic [15:0] cfg_min    = esm_pkg::RST_STALL_MIN_COUNT;

   // measurement and window state copies
   logic [15:0] last_count = '0;
   logic [31:0] last_time  = '0;
   logic [31:0] win_start  = '0;
   logic [15:0] win_accum  = '0;
   logic        fault_q    = 1'b0;
   logic        online_q   = 1'b0;

   // stimulus position, so random sequences carry on from the last tick
   logic [15:0] stim_count = '0;
   logic [31:0] stim_time  = '0;
   logic        stalled    = 1'b0;

   int  error_count     = 0;
   int  cycle_count     = 0;
   int  ready_wait      = 0;
   int  rsp_hold_cycles = 0;
   bit  rsp_taken       = 1'b0;
   bit  steady_flow     = 1'b0;

   always #5 clock = ~clock;

   encoder_speed_and_stall_monitor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // run time guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d",
               cycle_count, what, got, want);
      error_count++;
   endtask

   function automatic tick_type make_tick(logic [15:0] c, logic [31:0] n,
                                          logic [15:0] tg, logic l);
      tick_type t;
      t.count  = c;
      t.now    = n;
      t.target = tg;
      t.link   = l;
      return t;
   endfunction

   // speed, target and window decision for one accepted tick
   function automatic void predict_speed_and_flags(tick_type t);
      logic [15:0]        diff;
      int                 delta;
      logic [31:0]        dt;
      logic [31:0]        elapsed;
      longint             num;
      longint             den;
      longint             q;
      logic [15:0]        mag;
      logic [15:0]        cpr_used;
      logic signed [15:0] tgt;
      logic               moving;
      reading_type        r;
      diff       = t.count - last_count;
      delta      = int'($signed(diff));
      dt         = t.now - last_time;
      last_count = t.count;
      last_time  = t.now;
      if (dt == 0) dt = 32'd1;
      cpr_used = (cfg_cpr == 16'd0) ? 16'd1 : cfg_cpr;
      num = longint'(delta) * RpmScale;
      den = longint'(cpr_used) * longint'(dt);
      q   = num / den;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      tgt = t.link ? t.target : 16'sd0;
      // absolute delta into the window sum, wrapping at 16 bits
      mag       = (delta < 0) ? 16'(-delta) : 16'(delta);
      win_accum = win_accum + mag;
      elapsed   = t.now - win_start;
      if (elapsed >= {16'd0, cfg_window}) begin
         moving = (win_accum >= cfg_min);
         if (tgt != 0) fault_q = !moving;
         online_q  = (tgt != 0) && moving;
         win_accum = '0;
         win_start = t.now;
      end
      r.speed      = q[15:0];
      r.eff_target = tgt;
      r.fault      = fault_q;
      r.online     = online_q;
      expected_readings.push_back(r);
   endfunction

   // compare each rsp transfer with the oldest prediction
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_taken = 1'b1;
         if (expected_readings.size() == 0) begin
            report_mismatch("reading with nothing predicted", rsp_tdata[33:0], 0);
         end else begin
            want = expected_readings.pop_front();
            if ($signed(rsp_tdata[15:0]) !== want.speed)
               report_mismatch("speed_rpm", $signed(rsp_tdata[15:0]), want.speed);
            if ($signed(rsp_tdata[31:16]) !== want.eff_target)
               report_mismatch("effective_target", $signed(rsp_tdata[31:16]),
                               want.eff_target);
            if (rsp_tdata[32] !== want.fault)
               report_mismatch("stall_fault", rsp_tdata[32], want.fault);
            if (rsp_tdata[33] !== want.online)
               report_mismatch("drive_online", rsp_tdata[33], want.online);
         end
      end
   end

   // receiver: random wait after each transfer, plus an optional long hold-off
   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_taken  = 1'b0;
         ready_wait = steady_flow ? 0 : $urandom_range(0, 5);
      end
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_tready <= 1'b0;
      end else if (ready_wait > 0) begin
         ready_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // offer one tick, predict it at the transfer; valid stays high afterwards
   task automatic send_tick(tick_type t);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, t.link, t.target, t.now, t.count};
      do @(posedge clock); while (!req_tready);
      predict_speed_and_flags(t);
      stim_count = t.count;
      stim_time  = t.now;
   endtask

   task automatic release_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_csr(logic [esm_pkg::CsrIdxWidth-1:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         esm_pkg::REG_COUNTS_PER_REV:  cfg_cpr    = value;
         esm_pkg::REG_WINDOW_MS:       cfg_window = value;
         esm_pkg::REG_STALL_MIN_COUNT: cfg_min    = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // registers change only once every tick in flight has come back
   task automatic set_config(logic [15:0] cpr, logic [15:0] win, logic [15:0] mn);
      release_req();
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_csr(esm_pkg::REG_COUNTS_PER_REV, cpr);
      write_csr(esm_pkg::REG_WINDOW_MS, win);
      write_csr(esm_pkg::REG_STALL_MIN_COUNT, mn);
   endtask

   // mostly plausible motion with random content, some pure noise
   task automatic send_random_ticks(int n);
      tick_type    t;
      int          dc;
      logic [31:0] step_max;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 24) == 0) stalled = !stalled;
         if ($urandom_range(0, 99) < 85) begin
            step_max = {16'd0, cfg_window >> 3} + 32'd2;
            if (stalled) dc = $urandom_range(0, 1);
            else if ($urandom_range(0, 29) == 0) dc = $urandom_range(0, 65535);
            else dc = $urandom_range(1, 60);
            if ($urandom_range(0, 1)) dc = -dc;
            t.count  = stim_count + 16'(dc);
            t.now    = stim_time + $urandom_range(0, step_max);
            t.target = ($urandom_range(0, 9) == 0) ? 16'sd0 : 16'($urandom);
            t.link   = ($urandom_range(0, 9) != 0);
         end else begin
            t.count  = 16'($urandom);
            t.now    = $urandom;
            t.target = 16'($urandom);
            t.link   = 1'($urandom);
         end
         send_tick(t);
      end
      steady_flow = 1'b0;
   endtask

   // reset state, delta extremes, timestamp wrap and the flag rules
   task automatic test_reset_and_extremes();
      send_tick(make_tick(16'h0010, 32'd0, 16'h7FFF, 1'b1));   // zero dt against time zero
      send_tick(make_tick(16'h800F, 32'd1, 16'h8000, 1'b1));   // largest positive delta
      send_tick(make_tick(16'h000F, 32'd1, 16'h0001, 1'b1));   // most negative, same time
      send_tick(make_tick(16'h0012, 32'd700, 16'd1234, 1'b0)); // link down, window ends
      send_tick(make_tick(16'h0012, 32'd1300, 16'd500, 1'b1)); // no motion: fault
      send_tick(make_tick(16'h0012, 32'd1900, 16'd0, 1'b1));   // zero command keeps fault
      send_tick(make_tick(16'h0040, 32'd2500, 16'hFE0C, 1'b1));// moving: fault clears
      send_tick(make_tick(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
      send_tick(make_tick(16'h0000, 32'h0000_0004, 16'h0000, 1'b0)); // timestamp wraps
   endtask

   // widest and narrowest register settings, sum wrap, out of range zeros
   task automatic test_window_settings();
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tick(make_tick(stim_count + 16'd100, stim_time + 32'd10, 16'd300, 1'b1));
      // window sum wraps past 16 bits
      repeat (4) send_tick(make_tick(stim_count + 16'h7FFF, stim_time + 32'd1,
                                     16'd300, 1'b1));
      send_tick(make_tick(stim_count, stim_time + 32'd70000, 16'd300, 1'b1));
      // zero counts per rev and zero window, every tick ends a window
      set_config(16'd0, 16'd0, 16'd0);
      send_tick(make_tick(stim_count + 16'd3, stim_time + 32'd2, 16'd10, 1'b1));
      send_tick(make_tick(stim_count, stim_time, 16'd10, 1'b1));
      send_tick(make_tick(stim_count - 16'd7, stim_time + 32'd1, 16'd0, 1'b1));
      set_config(16'd1, 16'd1, 16'd1);
      send_tick(make_tick(stim_count, stim_time + 32'd1, 16'h8000, 1'b1));
      send_tick(make_tick(stim_count + 16'd1, stim_time + 32'd1, 16'h7FFF, 1'b1));
   endtask

   task automatic test_random_traffic(int n, logic [15:0] cpr, logic [15:0] win,
                                      logic [15:0] mn);
      set_config(cpr, win, mn);
      send_random_ticks(n);
   endtask

   // receiver holds off while ticks keep coming, so the input stalls
   task automatic test_backpressure();
      set_config(16'd7, 16'd20, 16'd10);
      send_random_ticks(10);
      @(posedge clock);
      rsp_hold_cycles = 400;
      send_random_ticks(140);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_and_extremes();
      test_window_settings();
      test_random_traffic(400, esm_pkg::RST_COUNTS_PER_REV, esm_pkg::RST_WINDOW_MS,
                          esm_pkg::RST_STALL_MIN_COUNT);
      test_random_traffic(300, 16'd1, 16'd1, 16'd0);
      test_random_traffic(200, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      test_backpressure();
      for (int k = 0; k < 3; k++)
         test_random_traffic(300, 16'($urandom_range(1, 200)), 16'($urandom_range(1, 50)),
                             16'($urandom_range(0, 100)));

      // drain, then let the pipeline settle
      release_req();
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (expected_readings.size() != 0)
         report_mismatch("readings never seen", expected_readings.size(), 0);

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
